### design/assert_macros.svh
// assertion macros shared by the stack machine rtl
// needs aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped during reset
`define ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sme_pkg.sv
// shared types, constants and helpers for the stack machine executor
// no dependencies
`timescale 1ns / 1ps

package sme_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = 8;
    localparam int DATA_W      = 64;
    localparam int HALF_W      = DATA_W / 2;
    localparam int FUNC_W      = 4;

    // instruction codes
    localparam logic [FUNC_W-1:0] FN_HALT = 4'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH = 4'd1;
    localparam logic [FUNC_W-1:0] FN_DROP = 4'd2;
    localparam logic [FUNC_W-1:0] FN_ADD  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_SUB  = 4'd4;
    localparam logic [FUNC_W-1:0] FN_MUL  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_XOR  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_AND  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_OR   = 4'd8;

    // multiplier partial product steps
    localparam logic [1:0] MUL_LL  = 2'd0;
    localparam logic [1:0] MUL_LH  = 2'd1;
    localparam logic [1:0] MUL_HL  = 2'd2;
    localparam logic [1:0] MUL_SUM = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic              do_push;
        logic              do_halt;
        logic              do_drop;
        logic              do_read_below;
        logic              do_refill;
        logic              do_writeback;
        logic              mul_en;
        logic [1:0]        mul_step;
        logic [FUNC_W-1:0] func;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;
    } sts_t;

    // stack store entry addressed by a pointer value
    function automatic logic [ADDR_W-1:0] stack_index(input logic [SP_W-1:0] sp);
        logic [31:0] wide;
        wide = 32'(sp) % STACK_DEPTH;
        return wide[ADDR_W-1:0];
    endfunction

endpackage

### design/sme_mul.sv
// 64-bit low-half multiplier built from three 32x32 partial products
// depends on sme_pkg
`timescale 1ns / 1ps

module sme_mul (
    input  logic                       aclk,
    input  logic                       mul_en,
    input  logic [1:0]                 mul_step,
    input  logic [sme_pkg::DATA_W-1:0] lhs,
    input  logic [sme_pkg::DATA_W-1:0] rhs,
    output logic [sme_pkg::DATA_W-1:0] product
);
    import sme_pkg::*;

    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [DATA_W-1:0] prod_full;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] cross_term;

    // operand halves for the current step
    always_comb begin
        case (mul_step)
            MUL_LL: begin
                mul_a = lhs[HALF_W-1:0];
                mul_b = rhs[HALF_W-1:0];
            end
            MUL_LH: begin
                mul_a = lhs[HALF_W-1:0];
                mul_b = rhs[DATA_W-1:HALF_W];
            end
            MUL_HL: begin
                mul_a = lhs[DATA_W-1:HALF_W];
                mul_b = rhs[HALF_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // cross products only reach the upper half
    assign cross_term = {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};

    // accumulate the previous partial product
    always_comb begin
        case (mul_step)
            MUL_LH:  acc_next = prod_reg;
            MUL_HL:  acc_next = acc_reg + cross_term;
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_full;
            acc_reg  <= acc_next;
        end
    end

    assign product = acc_reg + cross_term;

endmodule

### design/sme_datapath.sv
// datapath: stack store, cached top entry, pointer, alu and result register
// depends on sme_pkg, sme_mul and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sme_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sme_pkg::cmd_t              cmd,
    output sme_pkg::sts_t              sts,
    input  logic [sme_pkg::DATA_W-1:0] s_operand,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [sme_pkg::DATA_W-1:0] m_result_value
);
    import sme_pkg::*;

    logic [DATA_W-1:0]      mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] vld_reg;
    logic [DATA_W-1:0]      rd_data_reg;
    logic                   rd_vld_reg;
    logic [DATA_W-1:0]      rd_val;

    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic [SP_W-1:0]   sp_inc;
    logic [SP_W-1:0]   sp_dec;
    logic [DATA_W-1:0] tos_reg;
    logic [DATA_W-1:0] tos_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic [DATA_W-1:0] mul_product;
    logic [DATA_W-1:0] alu_result;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [DATA_W-1:0] m_result_reg;

    assign sp_inc = sp_reg + 1'b1;
    assign sp_dec = sp_reg - 1'b1;

    // entries never written read as zero
    assign rd_val = rd_vld_reg ? rd_data_reg : '0;

    sme_mul u_mul (
        .aclk     (aclk),
        .mul_en   (cmd.mul_en),
        .mul_step (cmd.mul_step),
        .lhs      (rd_val),
        .rhs      (tos_reg),
        .product  (mul_product)
    );

    // second-from-top is the left operand, cached top the right
    always_comb begin
        case (cmd.func)
            FN_ADD:  alu_result = rd_val + tos_reg;
            FN_SUB:  alu_result = rd_val - tos_reg;
            FN_MUL:  alu_result = mul_product;
            FN_XOR:  alu_result = rd_val ^ tos_reg;
            FN_AND:  alu_result = rd_val & tos_reg;
            FN_OR:   alu_result = rd_val | tos_reg;
            default: alu_result = '0;
        endcase
    end

    // store port control
    assign wr_en   = cmd.do_push | cmd.do_writeback;
    assign wr_addr = cmd.do_push ? stack_index(sp_inc) : stack_index(sp_dec);
    assign wr_data = cmd.do_push ? s_operand : alu_result;
    assign rd_en   = cmd.do_halt | cmd.do_drop | cmd.do_read_below;
    assign rd_addr = cmd.do_halt ? stack_index('0) : stack_index(sp_dec);

    // stack store with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    // per-entry written flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // pointer update
    always_comb begin
        sp_next = sp_reg;
        if (cmd.do_push) begin
            sp_next = sp_inc;
        end else if (cmd.do_halt) begin
            sp_next = '0;
        end else if (cmd.do_drop || cmd.do_writeback) begin
            sp_next = sp_dec;
        end
    end

    // cached top entry, equal to the store at the pointer except while a refill is pending
    always_comb begin
        tos_next = tos_reg;
        if (cmd.do_push) begin
            tos_next = s_operand;
        end else if (cmd.do_refill) begin
            tos_next = rd_val;
        end else if (cmd.do_writeback) begin
            tos_next = alu_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg  <= '0;
            tos_reg <= '0;
        end else begin
            sp_reg  <= sp_next;
            tos_reg <= tos_next;
        end
    end

    // result register towards the output channel
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.do_halt) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_halt) begin
            m_result_reg <= tos_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_reg;
    assign sts.out_busy   = m_valid_reg & ~m_ready;

    // checks
    `ASSERT_HOLDS(a_halt_no_overwrite, cmd.do_halt, !(m_valid_reg && !m_ready),
        "halt would overwrite a result not yet taken")
    `ASSERT_NEXT(a_wb_pointer, cmd.do_writeback, sp_reg == SP_W'($past(sp_reg) - 1'b1),
        "writeback did not leave the pointer one below")
    `ASSERT_NEXT(a_push_top, cmd.do_push, tos_reg == $past(s_operand),
        "cached top does not hold the pushed value")

endmodule

### design/sme_ctrl.sv
// controller: decodes requests and sequences the datapath
// depends on sme_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sme_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [sme_pkg::FUNC_W-1:0] s_func,
    input  sme_pkg::sts_t              sts,
    output sme_pkg::cmd_t              cmd
);
    import sme_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REFILL = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_MUL_LH = 3'd3;
    localparam logic [2:0] ST_MUL_HL = 3'd4;
    localparam logic [2:0] ST_MUL_WB = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [FUNC_W-1:0] func_reg;
    logic [FUNC_W-1:0] func_next;
    logic              accept;
    logic [4:0]        cmd_bits;

    // in the idle state, a halt waits only while the previous result is still held
    assign s_ready = (state_reg == ST_IDLE) && !((s_func == FN_HALT) && sts.out_busy);
    assign accept  = s_valid && s_ready;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        func_next  = func_reg;
        cmd        = '0;
        cmd.func   = func_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FN_HALT: begin
                            cmd.do_halt = 1'b1;
                            state_next  = ST_REFILL;
                        end
                        FN_PUSH: begin
                            cmd.do_push = 1'b1;
                        end
                        FN_DROP: begin
                            cmd.do_drop = 1'b1;
                            state_next  = ST_REFILL;
                        end
                        FN_ADD, FN_SUB, FN_MUL, FN_XOR, FN_AND, FN_OR: begin
                            cmd.do_read_below = 1'b1;
                            func_next         = s_func;
                            state_next        = ST_EXEC;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REFILL: begin
                cmd.do_refill = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_EXEC: begin
                if (func_reg == FN_MUL) begin
                    cmd.mul_en   = 1'b1;
                    cmd.mul_step = MUL_LL;
                    state_next   = ST_MUL_LH;
                end else begin
                    cmd.do_writeback = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_MUL_LH: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MUL_LH;
                state_next   = ST_MUL_HL;
            end
            ST_MUL_HL: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MUL_HL;
                state_next   = ST_MUL_WB;
            end
            ST_MUL_WB: begin
                cmd.mul_step     = MUL_SUM;
                cmd.do_writeback = 1'b1;
                state_next       = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
    end

    assign cmd_bits = {cmd.do_push, cmd.do_halt, cmd.do_drop, cmd.do_read_below,
                       cmd.do_writeback};

    // checks
    `ASSERT_HOLDS(a_cmd_exclusive, 1'b1, $onehot0(cmd_bits),
        "more than one stack command in a cycle")
    `ASSERT_NEXT(a_halt_refill, accept && (s_func == FN_HALT), state_reg == ST_REFILL,
        "halt not followed by a refill of the top")
    `ASSERT_NEXT(a_mul_sequence, state_reg == ST_MUL_LH, state_reg == ST_MUL_HL,
        "multiply steps out of order")

endmodule

### design/stack_machine_executor.sv
// 64-bit stack machine executor, one instruction per input request: push is
// done in the idle state; drop and halt go on to a refill of the cached top
// from the registered read of the stack store, and add, sub, xor, and, or to
// a writeback with the left operand fetched by that read; mul steps through
// states as one shared 32x32 multiplier forms three partial products. A halt
// result sits in an output register, so later instructions are taken while it
// waits; only a further halt is held off until it is taken. The 256 x 64 stack
// store has a written flag per entry cleared at reset, so it reads as zero from
// reset with no clearing pass. Depends on sme_pkg, sme_ctrl and sme_datapath.
`timescale 1ns / 1ps

module stack_machine_executor (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [sme_pkg::FUNC_W-1:0] s_func,
    input  logic [sme_pkg::DATA_W-1:0] s_operand,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [sme_pkg::DATA_W-1:0] m_result_value
);
    import sme_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // instruction sequencing
    sme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .sts     (sts),
        .cmd     (cmd)
    );

    // stack, alu and result register
    sme_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_operand      (s_operand),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value)
    );

endmodule

### sim/tb.sv
// self-checking testbench for the 64-bit stack machine executor
// depends on sme_pkg and stack_machine_executor from the design folder
`timescale 1ns / 1ps

module tb;
    import sme_pkg::*;

    localparam int TARGET_REQUESTS = 1250;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int MAX_REPORTS     = 10;
    localparam int LIGHT_IDLE_PCT  = 11;
    localparam int HEAVY_IDLE_PCT  = 55;
    localparam logic [FUNC_W-1:0] FN_LAST_CODE = '1;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] operand;
        bit                wait_drain;
    } request_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [FUNC_W-1:0] s_func         = '0;
    logic [DATA_W-1:0] s_operand      = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [DATA_W-1:0] m_result_value;

    // local copy of the machine state
    logic [DATA_W-1:0] model_stack [STACK_DEPTH];
    logic [SP_W-1:0]   model_sp;

    request_t          pending_requests[$];
    logic [DATA_W-1:0] halt_values[$];
    request_t          next_req;
    bit                drain_next  = 1'b0;
    bit                stalled     = 1'b0;
    int                n_total     = 0;
    int                n_accepted  = 0;
    int                n_results   = 0;
    int                n_errors    = 0;
    int                n_drains    = 0;
    int                idle_cycles = 0;

    stack_machine_executor dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_operand      (s_operand),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value)
    );

    // clock, 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // stack model, depth 256 so the pointer addresses the store directly
    function automatic void push_model(input logic [DATA_W-1:0] value);
        model_sp = model_sp + 1'b1;
        model_stack[model_sp] = value;
    endfunction

    function automatic logic [DATA_W-1:0] pop_model();
        logic [DATA_W-1:0] value;
        value = model_stack[model_sp];
        model_sp = model_sp - 1'b1;
        return value;
    endfunction

    // apply one instruction to the model, queueing the value a halt returns
    function automatic void execute_instruction(input logic [FUNC_W-1:0] func,
                                                input logic [DATA_W-1:0] operand);
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] res;
        case (func)
            FN_HALT: begin
                halt_values.push_back(pop_model());
                model_sp = '0;
            end
            FN_PUSH: push_model(operand);
            FN_DROP: void'(pop_model());
            FN_ADD, FN_SUB, FN_MUL, FN_XOR, FN_AND, FN_OR: begin
                rhs = pop_model();
                lhs = pop_model();
                case (func)
                    FN_ADD:  res = lhs + rhs;
                    FN_SUB:  res = lhs - rhs;
                    FN_MUL:  res = lhs * rhs;
                    FN_XOR:  res = lhs ^ rhs;
                    FN_AND:  res = lhs & rhs;
                    default: res = lhs | rhs;
                endcase
                push_model(res);
            end
            default: ;
        endcase
    endfunction

    // idle mix by progress: light sender idling first, then heavy, then none
    function automatic int sender_idle_pct();
        if (n_accepted < n_total / 3) return LIGHT_IDLE_PCT;
        else if (n_accepted < 2 * n_total / 3) return HEAVY_IDLE_PCT;
        else return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (n_accepted < n_total / 3) return HEAVY_IDLE_PCT;
        else if (n_accepted < 2 * n_total / 3) return LIGHT_IDLE_PCT;
        else return 0;
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(DATA_W-1){1'b0}}};
            3:       return DATA_W'(1);
            4:       return {$urandom, 32'hFFFF_FFFF};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] random_binary_op();
        return FUNC_W'($urandom_range(int'(FN_ADD), int'(FN_OR)));
    endfunction

    task automatic queue_request(input logic [FUNC_W-1:0] func,
                                 input logic [DATA_W-1:0] operand);
        request_t req;
        req.func       = func;
        req.operand    = operand;
        req.wait_drain = drain_next;
        drain_next     = 1'b0;
        pending_requests.push_back(req);
    endtask

    // well-formed program: pushes, reductions, sometimes one pop too many, halt
    task automatic queue_program();
        int depth;
        int n_ops;
        depth = $urandom_range(1, 6);
        for (int i = 0; i < depth; i++) queue_request(FN_PUSH, random_word());
        n_ops = $urandom_range(0, depth);
        for (int i = 0; i < n_ops; i++) begin
            if ($urandom_range(9) == 0) queue_request(FN_PUSH, random_word());
            queue_request(random_binary_op(), random_word());
        end
        if ($urandom_range(7) == 0) queue_request(FN_DROP, random_word());
        queue_request(FN_HALT, random_word());
        if ($urandom_range(11) == 0) drain_next = 1'b1;
    endtask

    // driver: predicts each accepted request, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                execute_instruction(s_func, s_operand);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0
                    && !(pending_requests[0].wait_drain && halt_values.size() != 0)
                    && $urandom_range(99) >= sender_idle_pct()) begin
                    next_req = pending_requests.pop_front();
                    if (next_req.wait_drain) n_drains++;
                    s_valid   <= 1'b1;
                    s_func    <= next_req.func;
                    s_operand <= next_req.operand;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each halt result against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (halt_values.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("tb: unexpected result %h", m_result_value);
                end else begin
                    n_results++;
                    if (m_result_value !== halt_values[0]) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("tb: result %0d mismatch, expected %h got %h",
                                     n_results, halt_values[0], m_result_value);
                    end
                    void'(halt_values.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) stalled <= 1'b1;
        end
    end

    initial begin
        for (int i = 0; i < STACK_DEPTH; i++) model_stack[i] = '0;
        model_sp = '0;

        // directed: empty pops, pointer wrap both ways, extremes, every operation
        queue_request(FN_HALT, '1);
        queue_request(FN_DROP, '0);
        queue_request(FN_PUSH, '1);
        queue_request(FN_PUSH, DATA_W'(1));
        queue_request(FN_ADD, '1);
        queue_request(FN_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
        queue_request(FN_PUSH, DATA_W'(1));
        queue_request(FN_SUB, '0);
        queue_request(FN_PUSH, 64'hFFFF_FFFF_0000_0001);
        queue_request(FN_PUSH, 64'h1234_5678_9ABC_DEF0);
        queue_request(FN_MUL, '0);
        queue_request(FN_PUSH, 64'h5555_5555_5555_5555);
        queue_request(FN_XOR, '1);
        queue_request(FN_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(FN_AND, '0);
        queue_request(FN_PUSH, 64'h0F0F_0F0F_0F0F_0F0F);
        queue_request(FN_OR, '0);
        queue_request(FN_PUSH, '1);
        queue_request(FN_LAST_CODE, '1);
        queue_request(FN_OR + 1'b1, 64'h0123_4567_89AB_CDEF);
        queue_request(FN_HALT, '0);
        // single entry: binary op reads below the bottom of the stack
        queue_request(FN_PUSH, '0);
        queue_request(FN_SUB, '0);
        queue_request(FN_HALT, '0);

        // random: mostly programs, some noise, occasional drain pauses
        drain_next = 1'b1;
        while (pending_requests.size() < TARGET_REQUESTS) begin
            if ($urandom_range(99) < 75) begin
                queue_program();
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_request(FUNC_W'($urandom_range(int'(FN_LAST_CODE))),
                                  {$urandom, $urandom});
            end
        end
        n_total = pending_requests.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while ((n_accepted < n_total || halt_values.size() != 0) && !stalled)
            @(posedge aclk);
        if (!stalled) repeat (SETTLE_CYCLES) @(posedge aclk);

        if (stalled) $display("tb: watchdog expired after %0d idle cycles", STALL_LIMIT);
        n_errors += halt_values.size();
        $display("tb: %0d of %0d instructions issued, %0d halt results checked",
                 n_accepted, n_total, n_results);
        $display("tb: %0d drain pauses, %0d mismatches", n_drains, n_errors);
        if (!stalled && n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
